// ===== design/cpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants for the compensated pressure averaging core.
// ----------------------------------------------------------------------------
package cpa_pkg;

  // Default number of samples in one averaging block.
  localparam int SAMPLES_PER_RESULT_DEF = 20;
  // Default depth of the queue of block totals between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ADC_W      = 12;
  localparam int TOTAL_W    = 32;
  localparam int PRESSURE_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Water height bands for the compensation term.
  localparam logic [15:0] HEIGHT_LOW_LIMIT  = 16'd100;
  localparam logic [15:0] HEIGHT_BAND_START = 16'd200;
  localparam logic [15:0] HEIGHT_BAND_END   = 16'd300;
  // 0.75 of a height step expressed with four fraction bits.
  localparam logic [3:0]  HEIGHT_SCALE_Q4   = 4'd12;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_OFFSET = 3'd0,
    REG_GAIN          = 3'd1,
    REG_INTERCEPT     = 3'd2,
    REG_WATER_HEIGHT  = 3'd3,
    REG_SAMPLE_FLOOR  = 3'd4,
    REG_RESULT_FLOOR  = 3'd5
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic signed [16:0] SAMPLE_OFFSET_RST = 17'sd0;
  localparam logic signed [31:0] GAIN_RST          = 32'sd65536;
  localparam logic signed [23:0] INTERCEPT_RST     = 24'sd0;
  localparam logic [15:0]        WATER_HEIGHT_RST  = 16'd0;
  localparam logic [19:0]        SAMPLE_FLOOR_RST  = 20'd480;
  localparam logic [19:0]        RESULT_FLOOR_RST  = 20'd512;

  typedef struct packed {
    logic signed [16:0] sample_offset;
    logic signed [31:0] gain;
    logic signed [23:0] intercept;
    logic [15:0]        water_height;
    logic [19:0]        sample_floor;
    logic [19:0]        result_floor;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/compensated_pressure_average_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// compensated_pressure_average_core
// Compensates 12-bit pressure samples and emits the floored, saturated
// average of every block of SAMPLES_PER_RESULT samples.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  ------------------------------
//   in        sink       in_valid_i/stall_o   adc_sample_i  (12 bit)
//   out       source     out_valid_o/stall_i  pressure_o    (24 bit, Q.4)
//   cfg       sink       cfg_we_i             cfg_idx_i, cfg_data_i
//
// One sample beat is taken every cycle unless the input stalls. A sample
// passes the front pipeline (offset, 18x32 multiply, scale and clamp) before
// it is added to the block total; a finished total passes a small queue and
// the back pipeline (reciprocal multiply, remainder, correction) to the output
// register. The input stalls only while a block total meets a full queue; the
// back end holds while the output beat is stalled. Reset clears all control
// state and loads the configuration reset values; no clearing pass is needed.
//
module compensated_pressure_average_core #(
  parameter int SAMPLES_PER_RESULT = cpa_pkg::SAMPLES_PER_RESULT_DEF,
  parameter int QUEUE_DEPTH        = cpa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [cpa_pkg::ADC_W-1:0]        adc_sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [cpa_pkg::PRESSURE_W-1:0]        pressure_o
);
  import cpa_pkg::*;

  cfg_t               cfg_q;
  logic               push;
  logic [TOTAL_W-1:0] push_total;
  logic               full;
  logic               pop;
  logic               avail;
  logic [TOTAL_W-1:0] pop_total;

  // Configuration registers. Unknown indexes are ignored. Writes must arrive only
  // while the core is idle (not enforced here); the pipelines read these directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_offset <= SAMPLE_OFFSET_RST;
      cfg_q.gain          <= GAIN_RST;
      cfg_q.intercept     <= INTERCEPT_RST;
      cfg_q.water_height  <= WATER_HEIGHT_RST;
      cfg_q.sample_floor  <= SAMPLE_FLOOR_RST;
      cfg_q.result_floor  <= RESULT_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SAMPLE_OFFSET: cfg_q.sample_offset <= cfg_data_i[16:0];
        REG_GAIN:          cfg_q.gain          <= cfg_data_i;
        REG_INTERCEPT:     cfg_q.intercept     <= cfg_data_i[23:0];
        REG_WATER_HEIGHT:  cfg_q.water_height  <= cfg_data_i[15:0];
        REG_SAMPLE_FLOOR:  cfg_q.sample_floor  <= cfg_data_i[19:0];
        REG_RESULT_FLOOR:  cfg_q.result_floor  <= cfg_data_i[19:0];
        default: begin
        end
      endcase
    end
  end

  // The front end compensates each sample and accumulates the block total.
  cpa_front #(
    .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .push_o       (push),
    .push_total_o (push_total),
    .full_i       (full)
  );

  // Finished block totals wait here so each side can stall independently.
  cpa_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_total),
    .full_o      (full),
    .pop_i       (pop),
    .avail_o     (avail),
    .pop_data_o  (pop_total)
  );

  // The back end turns a total into the averaged output beat.
  cpa_back #(
    .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (avail),
    .total_i     (pop_total),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pressure_o  (pressure_o)
  );

endmodule
`default_nettype wire

// ===== design/cpa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_front
// Per-sample compensation pipeline and block accumulator.
// ----------------------------------------------------------------------------
module cpa_front #(
  parameter int SAMPLES_PER_RESULT = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cpa_pkg::cfg_t                 cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cpa_pkg::ADC_W-1:0]     adc_sample_i,
  output logic                               push_o,
  output logic [cpa_pkg::TOTAL_W-1:0]        push_total_o,
  input  wire logic                          full_i
);
  import cpa_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

  logic             adv;
  logic             accept;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  logic               s1_v_q, s2_v_q, s3_v_q;
  logic               s1_last_q, s2_last_q, s3_last_q;
  logic signed [17:0] diff;
  logic signed [17:0] s1_diff_q;
  logic signed [49:0] s2_prod_q;
  logic [31:0]        s3_add_q;

  logic [TOTAL_W-1:0] total_q;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;

  logic [6:0]         hd;
  logic [10:0]        corr_mag;
  logic signed [35:0] corr;
  logic signed [35:0] val;
  logic [31:0]        addend;

  // The whole pipeline holds only when a block total cannot enter the queue.
  assign adv        = !(s3_v_q && s3_last_q && full_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  assign last  = (cnt_q == CNT_LAST);
  assign cnt_d = last ? '0 : cnt_q + CNT_W'(1);

  assign diff = $signed({2'b00, adc_sample_i, 4'b0000}) -
                18'($signed(cfg_i.sample_offset));

  // Height correction: subtract 0.75*h for low heights, add 0.75*(h-200) in the band.
  always_comb begin
    hd   = '0;
    corr = '0;
    if (cfg_i.water_height <= HEIGHT_LOW_LIMIT) begin
      hd = cfg_i.water_height[6:0];
    end else if (cfg_i.water_height > HEIGHT_BAND_START &&
                 cfg_i.water_height <= HEIGHT_BAND_END) begin
      hd = 7'(cfg_i.water_height - HEIGHT_BAND_START);
    end
    corr_mag = 11'(hd * HEIGHT_SCALE_Q4);
    if (cfg_i.water_height <= HEIGHT_LOW_LIMIT) begin
      corr = -$signed({25'd0, corr_mag});
    end else begin
      corr = $signed({25'd0, corr_mag});
    end
  end

  // Arithmetic shift of the product floors toward minus infinity.
  assign val = 36'($signed(s2_prod_q[49:16])) + 36'($signed(cfg_i.intercept)) + corr;

  always_comb begin
    if (val < $signed({16'd0, cfg_i.sample_floor})) begin
      addend = '0;
    end else if (val > $signed({4'd0, 32'hFFFF_FFFF})) begin
      addend = '1;
    end else begin
      addend = val[31:0];
    end
  end

  assign sum     = {1'b0, total_q} + {1'b0, s3_add_q};
  assign sum_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  assign push_o       = s3_v_q && s3_last_q && adv;
  assign push_total_o = sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      cnt_q   <= '0;
      total_q <= '0;
    end else if (adv) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (s3_v_q) begin
        total_q <= s3_last_q ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_diff_q <= diff;
      s1_last_q <= last;
      s2_prod_q <= 50'(s1_diff_q) * 50'($signed(cfg_i.gain));
      s2_last_q <= s1_last_q;
      s3_add_q  <= addend;
      s3_last_q <= s2_last_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/cpa_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_fifo
// Small queue of block totals between the front and back pipelines.
// ----------------------------------------------------------------------------
module cpa_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  input  wire logic [cpa_pkg::TOTAL_W-1:0] push_data_i,
  output logic                           full_o,
  input  wire logic                      pop_i,
  output logic                           avail_o,
  output logic [cpa_pkg::TOTAL_W-1:0]    pop_data_o
);
  import cpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [TOTAL_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o     = (count_q == CNT_FULL);
  assign avail_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/cpa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_back
// Divides block totals by the block size, applies the result floor and
// saturation, and holds the result in the output register.
// ----------------------------------------------------------------------------
module cpa_back #(
  parameter int SAMPLES_PER_RESULT = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cpa_pkg::cfg_t                 cfg_i,
  input  wire logic                          avail_i,
  input  wire logic [cpa_pkg::TOTAL_W-1:0]   total_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [cpa_pkg::PRESSURE_W-1:0]     pressure_o
);
  import cpa_pkg::*;

  // Reciprocal floor((2^32-1)/N): the first quotient estimate is at most two
  // below the true quotient, so the remainder stays below 3*N.
  localparam logic [31:0] RECIP = 32'((64'hFFFF_FFFF) / SAMPLES_PER_RESULT);
  localparam int R_W = $clog2(3 * SAMPLES_PER_RESULT + 1);
  localparam logic [R_W-1:0] DIV_N  = R_W'(SAMPLES_PER_RESULT);
  localparam logic [R_W-1:0] DIV_2N = R_W'(2 * SAMPLES_PER_RESULT);

  logic               adv;
  logic               b1_v_q, b2_v_q, out_v_q;
  logic [63:0]        b1_prod_q;
  logic [TOTAL_W-1:0] b1_total_q;
  logic [TOTAL_W-1:0] q0;
  logic [TOTAL_W-1:0] b2_q0_q;
  logic [R_W-1:0]     b2_rem_q;
  logic [TOTAL_W-1:0] avg;
  logic [PRESSURE_W-1:0] result;
  logic [PRESSURE_W-1:0] pressure_q;

  assign adv   = !(out_v_q && out_stall_i);
  assign pop_o = adv && avail_i;

  assign q0 = b1_prod_q[63:32];

  always_comb begin
    if (b2_rem_q >= DIV_2N) begin
      avg = b2_q0_q + TOTAL_W'(2);
    end else if (b2_rem_q >= DIV_N) begin
      avg = b2_q0_q + TOTAL_W'(1);
    end else begin
      avg = b2_q0_q;
    end
    if (avg < {12'd0, cfg_i.result_floor}) begin
      result = '0;
    end else if (avg > TOTAL_W'({PRESSURE_W{1'b1}})) begin
      result = '1;
    end else begin
      result = avg[PRESSURE_W-1:0];
    end
  end

  assign out_valid_o = out_v_q;
  assign pressure_o  = pressure_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q  <= avail_i;
      b2_v_q  <= b1_v_q;
      out_v_q <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_prod_q  <= 64'(total_i) * 64'(RECIP);
      b1_total_q <= total_i;
      b2_q0_q    <= q0;
      b2_rem_q   <= R_W'(b1_total_q - TOTAL_W'(q0 * TOTAL_W'(SAMPLES_PER_RESULT)));
      pressure_q <= result;
    end
  end

endmodule
`default_nettype wire

// ===== test/compensated_pressure_average_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// compensated_pressure_average_core_test
// Self-checking testbench for the compensated pressure averaging core. A
// cycle-level predictor follows every accepted sample beat and queues the
// expected block average; a monitor compares every output beat against it.
// ----------------------------------------------------------------------------
module compensated_pressure_average_core_test;
  import cpa_pkg::*;

  // The core is built with its default block size.
  localparam int SAMPLES_PER_BLOCK = SAMPLES_PER_RESULT_DEF;
  // Cycles that cover the front pipeline, the total queue and the back end.
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 630;
  localparam int CYCLE_LIMIT  = 200000;
  // Indexes that no register answers to; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint BLOCK_TOTAL_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [PRESSURE_W-1:0] PRESSURE_MAX = '1;

  // Every input is known from time zero.
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [ADC_W-1:0]      adc_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [PRESSURE_W-1:0] pressure_o;

  // Predictor state: its own copy of the registers and of the block total.
  cfg_t                  model_cfg;
  logic [TOTAL_W-1:0]    block_total;
  int unsigned           block_count;
  logic [PRESSURE_W-1:0] expected_pressure[$];

  int  errors = 0;
  int  cycles = 0;
  // When set, neither side inserts idle cycles.
  bit  steady = 1'b0;

  compensated_pressure_average_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .adc_sample_i (adc_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pressure_o   (pressure_o)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random with 18 percent probability, except in steady stretches.
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 18);
  end

  // Watchdog. Ends the run with an error report once CYCLE_LIMIT is passed.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Every accepted output beat must match the oldest pending block average.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pressure.size() == 0) begin
        errors++;
        $display("%0t: unexpected pressure beat: expected none, actual %0d",
                 $time, pressure_o);
      end else begin
        if (pressure_o !== expected_pressure[0]) begin
          errors++;
          $display("%0t: pressure mismatch: expected %0d, actual %0d",
                   $time, expected_pressure[0], pressure_o);
        end
        void'(expected_pressure.pop_front());
      end
    end
  end

  // Compensated value of one sample, clamped to what the block total can take.
  // Values below the sample floor, negative ones included, count as zero.
  function automatic logic [TOTAL_W-1:0] compensated_value(input logic [ADC_W-1:0] s);
    longint      v;
    logic [15:0] h;
    h = model_cfg.water_height;
    v = longint'(s) * 16 - longint'($signed(model_cfg.sample_offset));
    // The product is at most 49 bits wide, and >>> floors toward minus infinity.
    v = (v * longint'($signed(model_cfg.gain))) >>> 16;
    v = v + longint'($signed(model_cfg.intercept));
    // 0.75 of a height step is 12 in Q.4.
    if (h <= HEIGHT_LOW_LIMIT) begin
      v = v - longint'(HEIGHT_SCALE_Q4) * longint'(h);
    end else if (h > HEIGHT_BAND_START && h <= HEIGHT_BAND_END) begin
      v = v + longint'(HEIGHT_SCALE_Q4) * longint'(h - HEIGHT_BAND_START);
    end
    if (v < longint'(model_cfg.sample_floor)) begin
      return '0;
    end else if (v > BLOCK_TOTAL_MAX) begin
      return '1;
    end
    return v[TOTAL_W-1:0];
  endfunction

  // Adds one accepted sample to the block; the last one of a block queues
  // the floored and saturated average.
  task automatic absorb_sample(input logic [ADC_W-1:0] s);
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] avg;
    sum = {1'b0, block_total} + compensated_value(s);
    block_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    block_count++;
    if (block_count >= SAMPLES_PER_BLOCK) begin
      avg = block_total / SAMPLES_PER_BLOCK;
      if (avg < model_cfg.result_floor) begin
        avg = '0;
      end
      expected_pressure.push_back(avg > PRESSURE_MAX ? PRESSURE_MAX : avg[PRESSURE_W-1:0]);
      block_total = '0;
      block_count = 0;
    end
  endtask

  // Sends one sample beat. Called and returning at a falling edge; valid is
  // left high so back-to-back beats need no extra cycle.
  task automatic send_sample(input logic [ADC_W-1:0] s);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    absorb_sample(s);
    @(negedge clk_i);
  endtask

  // Pauses the sample stream until every pending average has come out.
  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_pressure.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Makes the core idle: no average pending and no sample left in flight.
  task automatic quiesce();
    hold_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One register write; the predictor keeps only the bits the register holds.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SAMPLE_OFFSET: model_cfg.sample_offset = data[16:0];
      REG_GAIN:          model_cfg.gain          = data[31:0];
      REG_INTERCEPT:     model_cfg.intercept     = data[23:0];
      REG_WATER_HEIGHT:  model_cfg.water_height  = data[15:0];
      REG_SAMPLE_FLOOR:  model_cfg.sample_floor  = data[19:0];
      REG_RESULT_FLOOR:  model_cfg.result_floor  = data[19:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Writes all six registers. Unused upper data bits carry random junk.
  task automatic apply_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom; d[16:0] = c.sample_offset; write_reg(REG_SAMPLE_OFFSET, d);
    write_reg(REG_GAIN, c.gain);
    d = $urandom; d[23:0] = c.intercept;     write_reg(REG_INTERCEPT, d);
    d = $urandom; d[15:0] = c.water_height;  write_reg(REG_WATER_HEIGHT, d);
    d = $urandom; d[19:0] = c.sample_floor;  write_reg(REG_SAMPLE_FLOOR, d);
    d = $urandom; d[19:0] = c.result_floor;  write_reg(REG_RESULT_FLOOR, d);
  endtask

  // Mostly uniform samples, with the two rails picked more often.
  function automatic logic [ADC_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ADC_W'($urandom);
    endcase
  endfunction

  // Random settings, weighted toward values that give non-trivial averages
  // while still reaching the sign and saturation corners.
  task automatic random_config(output cfg_t c);
    logic [15:0] heights[14];
    heights = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd150, 16'd199,
                16'd200, 16'd201, 16'd250, 16'd299, 16'd300, 16'd301, 16'hFFFF};
    c.sample_offset = ($urandom_range(3) == 0) ? 17'($urandom)
                                               : 17'(int'($urandom_range(2000)) - 1000);
    case ($urandom_range(7))
      0:       c.gain = $urandom;
      1:       c.gain = -32'($urandom_range(65536));
      // Gains up to 1024.0 push many averages past the output maximum.
      2:       c.gain = 32'd65536 << $urandom_range(10);
      default: c.gain = 32'(65536 + int'($urandom_range(65536)) - 32768);
    endcase
    c.intercept = ($urandom_range(3) == 0) ? 24'($urandom)
                                           : 24'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(2))
      0:       c.water_height = heights[$urandom_range(13)];
      1:       c.water_height = 16'($urandom_range(400));
      default: c.water_height = 16'($urandom);
    endcase
    c.sample_floor = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2000));
    c.result_floor = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2000));
  endtask

  // Rail and checkerboard samples at the reset settings; the low ones fall
  // under the per-sample floor. This is the first half of a block.
  task automatic test_field_extremes();
    logic [ADC_W-1:0] samples[10];
    samples = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h800,
                12'h7FF, 12'h001, 12'hFFE, 12'h000, 12'hFFF};
    foreach (samples[i]) send_sample(samples[i]);
  endtask

  // Finishes the open block under new settings. Writes to unmapped indexes
  // must change nothing. Lowest offset, highest gain and intercept make a
  // single sample exceed the 32-bit total, so the total and the output
  // saturate.
  task automatic test_register_change_mid_block();
    quiesce();
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    write_reg(REG_SAMPLE_OFFSET, 32'h0001_0000);
    write_reg(REG_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_INTERCEPT, 32'h007F_FFFF);
    repeat (SAMPLES_PER_BLOCK / 2) send_sample('1);
  endtask

  // One block per corner of the register ranges.
  task automatic test_register_extremes();
    cfg_t corners[5];
    corners[0] = '{sample_offset: 17'sh0FFFF, gain: 32'sh8000_0000,
                   intercept: 24'sh80_0000, water_height: 16'd0,
                   sample_floor: 20'd0, result_floor: 20'd0};
    corners[1] = '{sample_offset: 17'sh10000, gain: 32'sh7FFF_FFFF,
                   intercept: 24'sh7F_FFFF, water_height: 16'hFFFF,
                   sample_floor: 20'hFFFFF, result_floor: 20'hFFFFF};
    corners[2] = '{sample_offset: 17'sd0, gain: 32'sd65536,
                   intercept: 24'sh7F_FFFF, water_height: 16'd300,
                   sample_floor: 20'd0, result_floor: 20'd0};
    // Zero gain leaves only the height term, which drives every sample negative.
    corners[3] = '{sample_offset: 17'sd0, gain: 32'sd0,
                   intercept: 24'sd0, water_height: 16'd100,
                   sample_floor: 20'd0, result_floor: 20'd0};
    corners[4] = '{sample_offset: -17'sd1000, gain: 32'sd65536,
                   intercept: 24'sd0, water_height: 16'd201,
                   sample_floor: SAMPLE_FLOOR_RST, result_floor: RESULT_FLOOR_RST};
    foreach (corners[k]) begin
      quiesce();
      apply_config(corners[k]);
      repeat (SAMPLES_PER_BLOCK) send_sample(pick_sample());
    end
  endtask

  // Random settings and random phase lengths, so blocks often straddle a
  // change of settings. The fourth phase runs long with no idling on either
  // side; the first and some later ones pause halfway until all averages
  // are out.
  task automatic test_random_phases();
    cfg_t c;
    int   sent;
    int   n;
    int   phase;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      random_config(c);
      apply_config(c);
      steady = (phase == 3);
      n = steady ? 200 : $urandom_range(5, 60);
      for (int i = 0; i < n; i++) begin
        send_sample(pick_sample());
        if (i == n / 2 && (phase == 0 || $urandom_range(3) == 0)) begin
          hold_for_results();
        end
      end
      steady = 1'b0;
      sent  += n;
      phase++;
    end
  endtask

  initial begin
    model_cfg = '{sample_offset: SAMPLE_OFFSET_RST, gain: GAIN_RST,
                  intercept: INTERCEPT_RST, water_height: WATER_HEIGHT_RST,
                  sample_floor: SAMPLE_FLOOR_RST, result_floor: RESULT_FLOOR_RST};
    block_total = '0;
    block_count = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_field_extremes();
    test_register_change_mid_block();
    test_register_extremes();
    test_random_phases();

    quiesce();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/cpa_pkg.sv
design/cpa_front.sv
design/cpa_fifo.sv
design/cpa_back.sv
design/compensated_pressure_average_core.sv
test/compensated_pressure_average_core_test.sv
